// File: hdl/quadrature_position_logger_core_defines.svh
// Assertion macros shared by the checker of the position logger.
// Depends on nothing; included by files that carry assertions.
`ifndef QUADRATURE_POSITION_LOGGER_CORE_DEFINES_SVH
`define QUADRATURE_POSITION_LOGGER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define QPL_ASSERT_NOW(label, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define QPL_ASSERT_NEXT(label, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/qpl_pkg.sv
// Types, constants and decode helpers of the quadrature position logger.
// Depends on nothing; used by the front, queue, back, top level and bench.
package qpl_pkg;

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [31:0] SAMPLE_RESET   = 32'd20000;
  localparam logic [31:0] DEBOUNCE_RESET = 32'd5000;
  localparam logic [7:0]  THRESH_RESET   = 8'd20;
  localparam logic [31:0] STOP_RESET     = 32'd25920;
  localparam logic [15:0] MAXREC_RESET   = 16'd2047;
  localparam logic [7:0]  PRESS_MAX      = 8'd255;

  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE   = 3'd0,
    REG_DEBOUNCE = 3'd1,
    REG_THRESH   = 3'd2,
    REG_STOP     = 3'd3,
    REG_MAXREC   = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    STEP_NONE = 2'd0,
    STEP_FWD  = 2'd1,
    STEP_SKIP = 2'd2,
    STEP_BACK = 2'd3
  } step_t;

  typedef struct packed {
    logic [31:0] time_us;
    step_t       step;
    logic        button_level;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

  // Gray order 0,2,3,1 mapped to a step index.
  function automatic logic [1:0] phase_index(input logic [1:0] phase);
    logic [1:0] idx;
    case (phase)
      2'd0:    idx = 2'd0;
      2'd1:    idx = 2'd3;
      2'd2:    idx = 2'd1;
      default: idx = 2'd2;
    endcase
    return idx;
  endfunction

endpackage

// File: hdl/qpl_fifo.sv
// Short request queue between the front and the back of the logger.
// Depends on qpl_pkg for the entry and status types.
module qpl_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  qpl_pkg::q_entry_t   push_data,
  input  logic                pop,
  output qpl_pkg::q_entry_t   pop_data,
  output qpl_pkg::q_status_t  status
);
  import qpl_pkg::*;

  q_entry_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0]   count_r, count_nxt;
  logic                do_push, do_pop;

  assign status.full     = (count_r == QCNT_W'(QDEPTH));
  assign status.nonempty = (count_r != '0);
  assign do_push = push && !status.full;
  assign do_pop  = pop && status.nonempty;
  assign pop_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: hdl/qpl_front.sv
// Front of the logger: accepts polls and classifies the encoder step.
// Depends on qpl_pkg for the step decode and queue types.
module qpl_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [31:0]         in_time_us,
  input  logic                in_enc_lag_level,
  input  logic                in_enc_lead_level,
  input  logic                in_button_level,
  input  qpl_pkg::q_status_t  q_status,
  output logic                push,
  output qpl_pkg::q_entry_t   push_data
);
  import qpl_pkg::*;

  logic [1:0] last_phase_r, last_phase_nxt;
  logic [1:0] phase;

  assign phase    = {in_enc_lead_level, in_enc_lag_level};
  assign in_stall = q_status.full;
  assign push     = in_valid && !in_stall;

  always_comb begin
    last_phase_nxt         = push ? phase : last_phase_r;
    push_data.time_us      = in_time_us;
    push_data.step         = step_t'(phase_index(phase) - phase_index(last_phase_r));
    push_data.button_level = in_button_level;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_phase_r <= '0;
    end else begin
      last_phase_r <= last_phase_nxt;
    end
  end

endmodule

// File: hdl/qpl_back.sv
// Back of the logger: position, debounce, record and finish state, result register.
// Depends on qpl_pkg for the queue entry, step codes and register indexes.
module qpl_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [qpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]               cfg_data,
  input  qpl_pkg::q_status_t        q_status,
  input  qpl_pkg::q_entry_t         q_data,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      out_record_valid,
  output logic [31:0]               out_record_time,
  output logic signed [31:0]        out_record_position,
  output logic                      out_running,
  output logic                      out_finished,
  output logic [15:0]               out_records_logged,
  output logic [31:0]               out_error_total
);
  import qpl_pkg::*;

  logic [31:0] sample_r, debounce_r, stop_r;
  logic [7:0]  thresh_r;
  logic [15:0] maxrec_r;

  logic [31:0] position_r, position_nxt;
  logic [31:0] error_r, error_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [7:0]  press_r, press_nxt, press_sat;
  logic        pressed_r, pressed_nxt;
  logic        running_r, running_nxt;
  logic [15:0] rcount_r, rcount_nxt;
  logic        finished_r, finished_nxt;

  logic        rec;
  logic [31:0] diff;

  logic        ov_r, ov_nxt;
  logic        orv_r;
  logic [31:0] otime_r, opos_r;

  assign pop  = q_status.nonempty && (!ov_r || !out_stall);
  assign diff = q_data.time_us - last_time_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_r   <= SAMPLE_RESET;
      debounce_r <= DEBOUNCE_RESET;
      thresh_r   <= THRESH_RESET;
      stop_r     <= STOP_RESET;
      maxrec_r   <= MAXREC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SAMPLE:   sample_r   <= cfg_data;
        REG_DEBOUNCE: debounce_r <= cfg_data;
        REG_THRESH:   thresh_r   <= cfg_data[7:0];
        REG_STOP:     stop_r     <= cfg_data;
        REG_MAXREC:   maxrec_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    position_nxt  = position_r;
    error_nxt     = error_r;
    last_time_nxt = last_time_r;
    press_nxt     = press_r;
    pressed_nxt   = pressed_r;
    running_nxt   = running_r;
    rcount_nxt    = rcount_r;
    finished_nxt  = finished_r;
    rec           = 1'b0;
    press_sat     = (press_r < PRESS_MAX) ? press_r + 1'b1 : press_r;
    if (!finished_r) begin
      case (q_data.step)
        STEP_FWD:  position_nxt = position_r + 32'd1;
        STEP_BACK: position_nxt = position_r - 32'd1;
        STEP_SKIP: error_nxt    = error_r + 32'd1;
        default: ;
      endcase
      if (running_r && diff >= sample_r && rcount_r < maxrec_r) begin
        rec           = 1'b1;
        rcount_nxt    = rcount_r + 16'd1;
        last_time_nxt = q_data.time_us;
      end
      if (!running_r && !pressed_r && diff >= debounce_r) begin
        if (!q_data.button_level) begin
          press_nxt = press_sat;
          if (press_sat > thresh_r) begin
            pressed_nxt = 1'b1;
          end
        end else if (press_r != '0) begin
          press_nxt = press_r - 8'd1;
        end
        last_time_nxt = q_data.time_us;
      end
      if (pressed_nxt) begin
        running_nxt = 1'b1;
      end
      if (rcount_nxt >= maxrec_r || $signed(position_nxt) >= $signed(stop_r)) begin
        finished_nxt = 1'b1;
      end
    end
    ov_nxt = pop ? 1'b1 : (ov_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      position_r  <= '0;
      error_r     <= '0;
      last_time_r <= '0;
      press_r     <= '0;
      pressed_r   <= 1'b0;
      running_r   <= 1'b0;
      rcount_r    <= '0;
      finished_r  <= 1'b0;
      ov_r        <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
      if (pop) begin
        position_r  <= position_nxt;
        error_r     <= error_nxt;
        last_time_r <= last_time_nxt;
        press_r     <= press_nxt;
        pressed_r   <= pressed_nxt;
        running_r   <= running_nxt;
        rcount_r    <= rcount_nxt;
        finished_r  <= finished_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      orv_r   <= rec;
      otime_r <= rec ? q_data.time_us : '0;
      opos_r  <= rec ? position_nxt : '0;
    end
  end

  assign out_valid           = ov_r;
  assign out_record_valid    = orv_r;
  assign out_record_time     = otime_r;
  assign out_record_position = opos_r;
  assign out_running         = running_r;
  assign out_finished        = finished_r;
  assign out_records_logged  = rcount_r;
  assign out_error_total     = error_r;

endmodule

// File: hdl/quadrature_position_logger_core.sv
// Top level of the quadrature position logger: front, request queue and back.
// Depends on qpl_pkg, qpl_front, qpl_fifo and qpl_back.
//
// Each input request is one poll: a microsecond timestamp, both encoder pin
// levels and the start-button level. It is taken when in_valid is high and
// in_stall is low. Every poll yields exactly one result on the out_ channel,
// taken when out_valid is high and out_stall is low. The result carries an
// optional time/position record plus the running, finished, record count and
// error count state after the poll.
// The front classifies the encoder step against the previous phase and writes
// the poll into a two-entry queue; the back updates position, debounce and
// record state and loads the result register.
// A poll passes through a queue entry and then the result register; one poll
// per cycle is sustained while out_stall stays low.
// If the receiver stalls, the result register holds and the queue fills;
// in_stall rises once both queue entries are occupied.
// Configuration writes are accepted on every cycle (cfg_ready is high) and
// must only be issued while the block is idle.
// Synchronous reset restores the default intervals and limits and clears
// all position, debounce and record state; no result is pending after reset.
module quadrature_position_logger_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [31:0]                   in_time_us,
  input  logic                          in_enc_lag_level,
  input  logic                          in_enc_lead_level,
  input  logic                          in_button_level,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_record_valid,
  output logic [31:0]                   out_record_time,
  output logic signed [31:0]            out_record_position,
  output logic                          out_running,
  output logic                          out_finished,
  output logic [15:0]                   out_records_logged,
  output logic [31:0]                   out_error_total,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [qpl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);
  import qpl_pkg::*;

  q_status_t q_status;
  q_entry_t  push_data, pop_data;
  logic      push, pop;

  assign cfg_ready = 1'b1;

  qpl_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_time_us        (in_time_us),
    .in_enc_lag_level  (in_enc_lag_level),
    .in_enc_lead_level (in_enc_lead_level),
    .in_button_level   (in_button_level),
    .q_status          (q_status),
    .push              (push),
    .push_data         (push_data)
  );

  qpl_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  qpl_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .q_status            (q_status),
    .q_data              (pop_data),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_valid    (out_record_valid),
    .out_record_time     (out_record_time),
    .out_record_position (out_record_position),
    .out_running         (out_running),
    .out_finished        (out_finished),
    .out_records_logged  (out_records_logged),
    .out_error_total     (out_error_total)
  );

endmodule

// File: hdl/qpl_checker.sv
// Port-level checker of the quadrature position logger and its bind.
// Depends on quadrature_position_logger_core_defines.svh and the top level.
`include "quadrature_position_logger_core_defines.svh"

module qpl_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_record_valid,
  input logic [31:0] out_record_time,
  input logic [31:0] out_record_position,
  input logic        out_running,
  input logic        out_finished,
  input logic [15:0] out_records_logged
);

  logic seen_fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_fin_r <= 1'b0;
    end else if (out_valid && !out_stall && out_finished) begin
      seen_fin_r <= 1'b1;
    end
  end

  `QPL_ASSERT_NEXT(a_stall_hold, rst_n, out_valid && out_stall, out_valid && $stable(out_record_time) && $stable(out_records_logged), "stalled result changed")
  `QPL_ASSERT_NOW(a_frozen, rst_n, out_valid && seen_fin_r, out_finished && !out_record_valid, "result after finish is not frozen")
  `QPL_ASSERT_NOW(a_no_record_zero, rst_n, out_valid && !out_record_valid, out_record_time == 32'd0 && out_record_position == 32'd0, "empty record carries data")
  `QPL_ASSERT_NOW(a_record_running, rst_n, out_valid && out_record_valid, out_running && out_records_logged != 16'd0, "record while not running")

endmodule

bind quadrature_position_logger_core qpl_checker u_qpl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_record_valid    (out_record_valid),
  .out_record_time     (out_record_time),
  .out_record_position (out_record_position),
  .out_running         (out_running),
  .out_finished        (out_finished),
  .out_records_logged  (out_records_logged)
);

// File: bench/quadrature_position_logger_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for quadrature_position_logger_core: a directed table of polls, then
// random polls, each result checked against the table's want or a behavioural predictor.
// Depends on qpl_pkg and the quadrature_position_logger_core module.
module quadrature_position_logger_core_tb;
  import qpl_pkg::*;

  typedef struct packed {
    logic [31:0] time_us;
    logic        lag;
    logic        lead;
    logic        button;
  } poll_t;

  typedef struct packed {
    logic               record_valid;
    logic [31:0]        record_time;
    logic signed [31:0] record_position;
    logic               running;
    logic               finished;
    logic [15:0]        records_logged;
    logic [31:0]        error_total;
  } outcome_t;

  typedef struct packed {
    poll_t    poll;
    logic     typed;
    outcome_t want;
  } dir_row_t;

  typedef enum logic [1:0] {
    END_RECORDS,
    END_POSITION,
    END_NO_RECORDS,
    END_STOP_MIN
  } ending_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic [7:0] GRAY_RANK  = {2'd2, 2'd1, 2'd3, 2'd0};
  localparam logic [7:0] RANK_PHASE = {2'd1, 2'd3, 2'd2, 2'd0};

  localparam dir_row_t DIRECTED [18] = '{
    '{'{32'd0, 1'b0, 1'b0, 1'b1}, 1'b1, '{1'b0, 32'd0, 32'sd0, 1'b0, 1'b0, 16'd0, 32'd0}},
    '{'{32'd10, 1'b1, 1'b1, 1'b1}, 1'b1, '{1'b0, 32'd0, 32'sd0, 1'b0, 1'b0, 16'd0, 32'd1}},
    '{'{32'd20, 1'b0, 1'b0, 1'b0}, 1'b1, '{1'b0, 32'd0, 32'sd0, 1'b0, 1'b0, 16'd0, 32'd2}},
    '{'{32'd30, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
    '{'{32'd40, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
    '{'{32'd50, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'd60, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'd70, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'd80, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
    '{'{32'd90, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
    '{'{32'd100, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'd4998, 1'b1, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'd4999, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
    '{'{32'd10000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'd0, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'd5000, 1'b0, 1'b0, 1'b1}, 1'b0, '0},
    '{'{32'd7000, 1'b1, 1'b1, 1'b1}, 1'b0, '0}
  };

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_time_us = '0;
  logic                 in_enc_lag_level = 1'b0;
  logic                 in_enc_lead_level = 1'b0;
  logic                 in_button_level = 1'b1;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_record_valid;
  logic [31:0]          out_record_time;
  logic signed [31:0]   out_record_position;
  logic                 out_running;
  logic                 out_finished;
  logic [15:0]          out_records_logged;
  logic [31:0]          out_error_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  logic [31:0]        cfg_sample;
  logic [31:0]        cfg_debounce;
  logic [7:0]         cfg_thresh;
  logic signed [31:0] cfg_stop;
  logic [15:0]        cfg_maxrec;
  logic [1:0]         enc_phase;
  logic signed [31:0] pos_count;
  logic [31:0]        skip_errors;
  logic [31:0]        event_stamp;
  logic [7:0]         press_level;
  logic               btn_latched;
  logic               logging;
  logic               frozen;
  logic [15:0]        rec_total;

  outcome_t    outcome_q [$];
  outcome_t    oldest;
  int          mismatches = 0;
  bit          steady = 1'b0;
  logic [31:0] stamp_now = '0;
  logic [1:0]  pin_rank = '0;

  quadrature_position_logger_core DUT (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_time_us          (in_time_us),
    .in_enc_lag_level    (in_enc_lag_level),
    .in_enc_lead_level   (in_enc_lead_level),
    .in_button_level     (in_button_level),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_record_valid    (out_record_valid),
    .out_record_time     (out_record_time),
    .out_record_position (out_record_position),
    .out_running         (out_running),
    .out_finished        (out_finished),
    .out_records_logged  (out_records_logged),
    .out_error_total     (out_error_total),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic outcome_t advance_logger(input poll_t p);
    outcome_t   o;
    logic [1:0] next_phase;
    logic [1:0] rank_delta;
    o = '0;
    if (!frozen) begin
      next_phase = {p.lead, p.lag};
      rank_delta = GRAY_RANK[2*next_phase +: 2] - GRAY_RANK[2*enc_phase +: 2];
      case (step_t'(rank_delta))
        STEP_FWD: pos_count = pos_count + 32'sd1;
        STEP_BACK: pos_count = pos_count - 32'sd1;
        STEP_SKIP: skip_errors = skip_errors + 32'd1;
        default: ;
      endcase
      enc_phase = next_phase;
      if (logging && (p.time_us - event_stamp) >= cfg_sample && rec_total < cfg_maxrec) begin
        o.record_valid = 1'b1;
        o.record_time = p.time_us;
        o.record_position = pos_count;
        rec_total = rec_total + 16'd1;
        event_stamp = p.time_us;
      end
      if (!logging && !btn_latched && (p.time_us - event_stamp) >= cfg_debounce) begin
        if (!p.button) begin
          if (press_level < PRESS_MAX) press_level = press_level + 8'd1;
          if (press_level > cfg_thresh) btn_latched = 1'b1;
        end else if (press_level != 8'd0) begin
          press_level = press_level - 8'd1;
        end
        event_stamp = p.time_us;
      end
      if (btn_latched) logging = 1'b1;
      if (rec_total >= cfg_maxrec || pos_count >= cfg_stop) frozen = 1'b1;
    end
    o.running = logging;
    o.finished = frozen;
    o.records_logged = rec_total;
    o.error_total = skip_errors;
    return o;
  endfunction

  // Mostly legal encoder steps with occasional skips, and timestamps that often land
  // exactly on or just short of the interval that currently gates an event.
  function automatic poll_t next_poll(input int unsigned span, input bit press, input bit climb);
    poll_t       p;
    logic [31:0] gate;
    int unsigned pick;
    gate = logging ? cfg_sample : cfg_debounce;
    pick = $urandom_range(99);
    if (pick < 8) stamp_now = event_stamp + gate;
    else if (pick < 12) stamp_now = event_stamp + gate - 32'd1;
    else if (pick < 16) stamp_now = $urandom;
    else stamp_now = stamp_now + $urandom_range(span);
    pick = $urandom_range(99);
    if (climb || pick < 40) pin_rank = pin_rank + 2'd1;
    else if (pick < 75) pin_rank = pin_rank - 2'd1;
    else if (pick < 85) pin_rank = pin_rank + 2'd2;
    p.time_us = stamp_now;
    {p.lead, p.lag} = RANK_PHASE[2*pin_rank +: 2];
    p.button = press ? 1'b0 : 1'($urandom_range(1));
    return p;
  endfunction

  task automatic send_poll(input poll_t p, input logic typed, input outcome_t want);
    outcome_t predicted;
    while (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_time_us <= p.time_us;
    in_enc_lag_level <= p.lag;
    in_enc_lead_level <= p.lead;
    in_button_level <= p.button;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predicted = advance_logger(p);
    outcome_q.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SAMPLE: cfg_sample = val;
      REG_DEBOUNCE: cfg_debounce = val;
      REG_THRESH: cfg_thresh = val[7:0];
      REG_STOP: cfg_stop = val;
      REG_MAXREC: cfg_maxrec = val[15:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(negedge clk) out_stall <= !steady && ($urandom_range(99) < 37);

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (outcome_q.size() == 0) begin
        $error("result arrived with no request outstanding");
        mismatches++;
      end else begin
        oldest = outcome_q.pop_front();
        check_field("record_valid", oldest.record_valid, out_record_valid);
        check_field("record_time", oldest.record_time, out_record_time);
        check_field("record_position", oldest.record_position, out_record_position);
        check_field("running", oldest.running, out_running);
        check_field("finished", oldest.finished, out_finished);
        check_field("records_logged", oldest.records_logged, out_records_logged);
        check_field("error_total", oldest.error_total, out_error_total);
      end
    end
  end

  initial begin
    poll_t       probe;
    logic [31:0] gap;
    int unsigned span;
    ending_t     ending;
    int          guard;
    cfg_sample = SAMPLE_RESET;
    cfg_debounce = DEBOUNCE_RESET;
    cfg_thresh = THRESH_RESET;
    cfg_stop = STOP_RESET;
    cfg_maxrec = MAXREC_RESET;
    enc_phase = '0;
    pos_count = '0;
    skip_errors = '0;
    event_stamp = '0;
    press_level = '0;
    btn_latched = 1'b0;
    logging = 1'b0;
    frozen = 1'b0;
    rec_total = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (DIRECTED[i]) send_poll(DIRECTED[i].poll, DIRECTED[i].typed, DIRECTED[i].want);

    wait_idle();
    write_reg(REG_SPARE, $urandom);
    write_reg(REG_STOP, 32'h7FFF_FFFF);
    write_reg(REG_MAXREC, 32'h0000_FFFF);
    write_reg(REG_THRESH, {24'd0, PRESS_MAX});
    write_reg(REG_DEBOUNCE, 32'hFFFF_FFFF);
    // With the longest debounce interval only a poll stamped one below the last event time counts.
    probe = next_poll(1, 1'b1, 1'b0);
    probe.time_us = event_stamp - 32'd2;
    send_poll(probe, 1'b0, '0);
    probe.time_us = event_stamp - 32'd1;
    send_poll(probe, 1'b0, '0);

    wait_idle();
    write_reg(REG_DEBOUNCE, 32'd1);
    repeat (40) send_poll(next_poll(3, 1'b0, 1'b0), 1'b0, '0);
    wait_idle();
    // A held press saturates the debounce count, which cannot exceed the top threshold.
    write_reg(REG_DEBOUNCE, 32'd0);
    repeat (300) send_poll(next_poll(3, 1'b1, 1'b0), 1'b0, '0);

    wait_idle();
    write_reg(REG_THRESH, $urandom_range(1) ? 32'd0 : $urandom_range(254, 1));
    for (guard = 0; guard < 50 && !logging; guard++)
      send_poll(next_poll(3, 1'b1, 1'b0), 1'b0, '0);

    for (int phase = 0; phase < 5; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          gap = 32'd0;
          span = 4;
        end
        1: begin
          gap = $urandom_range(40, 1);
          span = 2 * gap;
        end
        2: begin
          gap = 32'hFFFF_FFFF;
          span = 1000;
        end
        3: begin
          gap = $urandom_range(2000, 100);
          span = gap;
        end
        default: begin
          gap = $urandom_range(20, 1);
          span = 30;
        end
      endcase
      write_reg(REG_SAMPLE, gap);
      write_reg(REG_DEBOUNCE, $urandom);
      steady = (phase == 4);
      repeat (100) send_poll(next_poll(span, 1'b0, 1'b0), 1'b0, '0);
      steady = 1'b0;
    end

    wait_idle();
    write_reg(REG_SAMPLE, 32'd0);
    ending = ending_t'($urandom_range(3));
    case (ending)
      END_RECORDS: write_reg(REG_MAXREC, {16'd0, rec_total + 16'($urandom_range(3, 1))});
      END_POSITION: write_reg(REG_STOP, pos_count + $urandom_range(3, 1));
      END_NO_RECORDS: write_reg(REG_MAXREC, 32'd0);
      default: write_reg(REG_STOP, 32'h8000_0000);
    endcase
    for (guard = 0; guard < 200 && !frozen; guard++)
      send_poll(next_poll(8, 1'b0, ending == END_POSITION), 1'b0, '0);
    repeat (20) send_poll(next_poll(8, 1'b0, 1'b0), 1'b0, '0);

    wait_idle();
    if (mismatches == 0 && outcome_q.size() == 0) begin
      $display("** quadrature_position_logger_core: PASSED **");
    end else begin
      $display("** quadrature_position_logger_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** quadrature_position_logger_core: FAILED **");
    $finish;
  end

endmodule
